>>> hdl/gmp_pkg.sv
// gmp_pkg: shared constants, register indexes and the sequencer-to-datapath
// control struct for the grid min pair L1 cost block. No dependencies.

package gmp_pkg;

  // Parameter defaults
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_PIXEL_BITS = 16;

  // Fixed field widths
  localparam int SIZE_BITS      = 9;
  localparam int COST_BITS      = 16;
  localparam int RESULT_BITS    = 18;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COST   = 2'd2;

  // Register reset values
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 9'd2;
  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 9'd2;
  localparam logic [COST_BITS-1:0] COST_RESET   = 16'd1;

  // Best cost before any pair has been seen
  localparam logic [RESULT_BITS-1:0] COST_ALL_ONES = '1;

  // One operation issued by the sequencer to the datapath
  typedef struct packed {
    logic issue;     // an operation enters the pipe this cycle
    logic load;      // pass one: pixel from the input, else from the image store
    logic has_up;    // a row neighbor exists (above in pass one, below in pass two)
    logic has_left;  // a left neighbor exists
    logic finish;    // move the result to the output register, clear the frame
  } gmp_ctrl_t;

endpackage

>>> hdl/gmp_seq.sv
// gmp_seq (depends on gmp_pkg): load / sweep sequencer. Owns row and column
// counters, issues one operation per cycle to gmp_core, in load on in_valid.

module gmp_seq #(
  parameter int MAX_HEIGHT = gmp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = gmp_pkg::DEF_MAX_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       h_eff,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        w_eff,
  output gmp_pkg::gmp_ctrl_t                    ctrl,
  output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] row,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   col
);
  import gmp_pkg::*;

  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [3:0] {
    S_LOAD   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;
  logic          col_last;
  logic          row_last;

  // End of row / end of grid tests (also catch counters beyond a shrunk size)
  assign col_last = (WW'(col) + WW'(1)) >= w_eff;
  assign row_last = (HW'(row) + HW'(1)) >= h_eff;

  // Next-state and issue logic
  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    ctrl       = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready      = 1'b1;
        ctrl.load     = 1'b1;
        ctrl.has_up   = (row != '0);
        ctrl.has_left = (col != '0);
        if (in_valid) begin
          ctrl.issue = 1'b1;
          if (!col_last) begin
            col_next = col + CW'(1);
          end else begin
            col_next = '0;
            if (!row_last) begin
              row_next = row + RW'(1);
            end else begin
              // pass two starts at the bottom row
              row_next   = RW'(h_eff - HW'(1));
              state_next = S_SWEEP;
            end
          end
        end
      end
      S_SWEEP: begin
        ctrl.issue    = 1'b1;
        ctrl.has_up   = !row_last;
        ctrl.has_left = (col != '0);
        if (!col_last) begin
          col_next = col + CW'(1);
        end else begin
          col_next = '0;
          if (row != '0) begin
            row_next = row - RW'(1);
          end else begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // last sweep operation is in the compute stage
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          ctrl.finish = 1'b1;
          state_next  = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      row   <= '0;
      col   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
    end
  end

endmodule

>>> hdl/gmp_core.sv
// gmp_core: image store, row minima store with read-modify-write forwarding,
// min-plus compute stage, best cost tracking and result register.
// Depends on gmp_pkg.

module gmp_core #(
  parameter int MAX_HEIGHT = gmp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = gmp_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = gmp_pkg::DEF_PIXEL_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  gmp_pkg::gmp_ctrl_t                    ctrl,
  input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] row,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0]   col,
  input  logic [PIXEL_BITS-1:0]                 pixel,
  input  logic [gmp_pkg::COST_BITS-1:0]         step_cost,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [gmp_pkg::RESULT_BITS-1:0]       min_cost,
  output logic                                  found
);
  import gmp_pkg::*;

  localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int IMG_DEPTH = 2 ** (RW + CW);
  localparam int SW        = ((PIXEL_BITS > COST_BITS) ? PIXEL_BITS : COST_BITS) + 2;

  // Storage
  logic [PIXEL_BITS-1:0] image_mem [IMG_DEPTH];
  logic [PIXEL_BITS-1:0] row_mem   [MAX_WIDTH];

  logic [RW+CW-1:0]      img_addr;
  logic [PIXEL_BITS-1:0] img_q;
  logic [PIXEL_BITS-1:0] row_q;

  // Compute stage registers
  logic                  b_vld;
  logic                  b_load;
  logic                  b_up;
  logic                  b_left;
  logic [CW-1:0]         b_col;
  logic [PIXEL_BITS-1:0] b_raw;
  logic                  fwd_hit;
  logic [PIXEL_BITS-1:0] fwd_data;

  // Running frame state
  logic [PIXEL_BITS-1:0]  left_min;
  logic [RESULT_BITS-1:0] best;
  logic                   pair_seen;

  // Compute stage signals
  logic [PIXEL_BITS-1:0]  v;
  logic [PIXEL_BITS-1:0]  nb;
  logic [SW-1:0]          up_reach;
  logic [SW-1:0]          up_cand;
  logic [SW-1:0]          left_reach;
  logic [SW-1:0]          left_cand;
  logic [PIXEL_BITS-1:0]  m_up;
  logic [PIXEL_BITS-1:0]  m_b;
  logic [RESULT_BITS-1:0] best_up;
  logic [RESULT_BITS-1:0] best_next;

  assign img_addr = {row, col};

  // Image store: written during load, read during sweep
  always_ff @(posedge clk) begin
    if (ctrl.issue && ctrl.load) begin
      image_mem[img_addr] <= pixel;
    end
    img_q <= image_mem[img_addr];
  end

  // Row minima store: read at issue, written back from the compute stage
  always_ff @(posedge clk) begin
    if (b_vld) begin
      row_mem[b_col] <= m_b;
    end
    row_q <= row_mem[col];
  end

  // Issue -> compute stage, with bypass when the write-back hits the read
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld   <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      b_vld   <= ctrl.issue;
      fwd_hit <= ctrl.issue && b_vld && (b_col == col);
    end
    fwd_data <= m_b;
    b_load   <= ctrl.load;
    b_up     <= ctrl.has_up;
    b_left   <= ctrl.has_left;
    b_col    <= col;
    b_raw    <= pixel;
  end

  // Min-plus step: row neighbor first, then left neighbor
  always_comb begin
    v          = b_load ? b_raw : img_q;
    nb         = fwd_hit ? fwd_data : row_q;
    up_reach   = SW'(nb) + SW'(step_cost);
    up_cand    = SW'(v) + up_reach;
    m_up       = (b_up && (up_reach < SW'(v))) ? PIXEL_BITS'(up_reach) : v;
    left_reach = SW'(left_min) + SW'(step_cost);
    left_cand  = SW'(v) + left_reach;
    m_b        = (b_left && (left_reach < SW'(m_up))) ? PIXEL_BITS'(left_reach) : m_up;
    best_up    = (b_up && (up_cand < SW'(best))) ? RESULT_BITS'(up_cand) : best;
    best_next  = (b_left && (left_cand < SW'(best_up))) ? RESULT_BITS'(left_cand) : best_up;
  end

  // Frame state; cleared when the result is taken into the output register
  always_ff @(posedge clk) begin
    if (rst || ctrl.finish) begin
      left_min  <= '0;
      best      <= COST_ALL_ONES;
      pair_seen <= 1'b0;
    end else if (b_vld) begin
      left_min  <= m_b;
      best      <= best_next;
      pair_seen <= pair_seen | b_up | b_left;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (ctrl.finish) begin
      min_cost <= pair_seen ? best : '0;
      found    <= pair_seen;
    end
  end

endmodule

>>> hdl/grid_min_pair_l1_cost.sv
// Grid min pair L1 cost: top level with configuration registers and size clamp.
// A grid of H x W pixels loads at one pixel per cycle while the block is in its load
// state; after the last pixel transfer the result follows one pass over the single-port
// image store. No pixel is taken during that pass, nor until the result has moved into
// the output register. Reset is synchronous, clears control state and loads height 2,
// width 2, step cost 1; no clearing pass is needed.

module grid_min_pair_l1_cost #(
  parameter int MAX_HEIGHT = gmp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = gmp_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = gmp_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [gmp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [PIXEL_BITS-1:0]               pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gmp_pkg::RESULT_BITS-1:0]     min_cost,
  output logic                                found
);
  import gmp_pkg::*;

  localparam int HW  = $clog2(MAX_HEIGHT+1);
  localparam int WW  = $clog2(MAX_WIDTH+1);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HCW = (HW > SIZE_BITS) ? HW : SIZE_BITS;
  localparam int WCW = (WW > SIZE_BITS) ? WW : SIZE_BITS;

  logic [SIZE_BITS-1:0] height_in_use;
  logic [SIZE_BITS-1:0] width_in_use;
  logic [COST_BITS-1:0] step_cost;
  logic [HCW-1:0]       h_ext;
  logic [WCW-1:0]       w_ext;
  logic [HW-1:0]        h_eff;
  logic [WW-1:0]        w_eff;
  gmp_ctrl_t            ctrl;
  logic [RW-1:0]        row;
  logic [CW-1:0]        col;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      height_in_use <= HEIGHT_RESET;
      width_in_use  <= WIDTH_RESET;
      step_cost     <= COST_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEIGHT: height_in_use <= cfg_data[SIZE_BITS-1:0];
        REG_WIDTH:  width_in_use  <= cfg_data[SIZE_BITS-1:0];
        REG_COST:   step_cost     <= cfg_data[COST_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Size clamp: zero counts as one, above the maximum counts as the maximum
  always_comb begin
    h_ext = HCW'(height_in_use);
    w_ext = WCW'(width_in_use);
    if (h_ext == '0) begin
      h_eff = HW'(1);
    end else if (h_ext > HCW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext[HW-1:0];
    end
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext[WW-1:0];
    end
  end

  gmp_seq #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .h_eff     (h_eff),
    .w_eff     (w_eff),
    .ctrl      (ctrl),
    .row       (row),
    .col       (col)
  );

  gmp_core #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .row       (row),
    .col       (col),
    .pixel     (pixel),
    .step_cost (step_cost),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_cost  (min_cost),
    .found     (found)
  );

endmodule

>>> hdl/gmp_check.sv
// gmp_check: port-level checks for grid_min_pair_l1_cost, attached by bind.
// Depends on gmp_pkg for the result width.

module gmp_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [gmp_pkg::RESULT_BITS-1:0] min_cost,
  input logic                            found
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(min_cost) && $stable(found))
    else $error("result changed or dropped while stalled");

  // No pair means a zero cost field
  a_no_pair_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> min_cost == '0)
    else $error("min_cost not zero for a single-cell grid");

  // A new result appears only after the sweep, when no pixel is taken
  a_result_after_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while pixels were being taken");

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_min_pair_l1_cost gmp_check u_gmp_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .min_cost  (min_cost),
  .found     (found)
);

>>> bench/gmp_checker.sv
`timescale 1ns / 100ps
// gmp_checker: watches the register, pixel and result channels of grid_min_pair_l1_cost,
// predicts the min pair cost of each grid and compares every result transfer.
// Depends on gmp_pkg for field widths, register indexes and reset values.

module gmp_checker #(
  parameter int MAX_HEIGHT = gmp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = gmp_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = gmp_pkg::DEF_PIXEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [gmp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gmp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [PIXEL_BITS-1:0]              pixel,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [gmp_pkg::RESULT_BITS-1:0]    min_cost,
  input  logic                               found,
  output int                                 results_due,
  output int                                 fail_count
);

  import gmp_pkg::*;

  typedef struct packed {
    logic [RESULT_BITS-1:0] cost;
    logic                   found;
  } pair_result_t;

  // Shadow registers
  logic [SIZE_BITS-1:0] rows_reg;
  logic [SIZE_BITS-1:0] cols_reg;
  logic [COST_BITS-1:0] cost_reg;

  // Predictor state for the grid being loaded
  logic [PIXEL_BITS-1:0] image_mem [MAX_HEIGHT*MAX_WIDTH];
  logic [PIXEL_BITS-1:0] above_min [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] below_min [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] run_left;
  longint unsigned       best_sum;
  bit                    any_pair;
  int unsigned           row_idx;
  int unsigned           col_idx;

  pair_result_t pair_cost_q[$];
  int           errors = 0;

  function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned limit);
    if (raw == 0) return 1;
    return (raw > limit) ? limit : raw;
  endfunction

  // Score v against neighbor minimum nb, fold nb + cost into the cell minimum m
  task automatic relax(input longint unsigned v, input longint unsigned nb,
                       inout longint unsigned m);
    longint unsigned cand;
    longint unsigned reach;
    reach = nb + cost_reg;
    cand  = v + reach;
    if (cand < best_sum) best_sum = cand;
    any_pair = 1'b1;
    if (reach < m) m = reach;
  endtask

  task automatic clear_grid();
    run_left = '0;
    best_sum = COST_ALL_ONES;
    any_pair = 1'b0;
    row_idx  = 0;
    col_idx  = 0;
  endtask

  // Second pass: bottom row to top, left to right, neighbors below and left
  task automatic sweep_up(input int unsigned h, input int unsigned w);
    longint unsigned       m;
    logic [PIXEL_BITS-1:0] left;
    logic [PIXEL_BITS-1:0] pv;
    for (int r = int'(h) - 1; r >= 0; r--) begin
      left = '0;
      for (int c = 0; c < int'(w); c++) begin
        pv = image_mem[r*MAX_WIDTH + c];
        m  = pv;
        if (r + 1 < int'(h)) relax(pv, below_min[c], m);
        if (c > 0) relax(pv, left, m);
        below_min[c] = m[PIXEL_BITS-1:0];
        left         = m[PIXEL_BITS-1:0];
      end
    end
  endtask

  // First pass runs per pixel; the last pixel of a grid produces the result
  task automatic take_pixel(input logic [PIXEL_BITS-1:0] v);
    int unsigned     h;
    int unsigned     w;
    int unsigned     r;
    int unsigned     c;
    longint unsigned m;
    bit              row_end;
    bit              grid_end;
    pair_result_t    res;
    h = clamp_dim(rows_reg, MAX_HEIGHT);
    w = clamp_dim(cols_reg, MAX_WIDTH);
    r = row_idx % MAX_HEIGHT;
    c = col_idx % MAX_WIDTH;
    m = v;
    image_mem[r*MAX_WIDTH + c] = v;
    if (r > 0) relax(v, above_min[c], m);
    if (c > 0) relax(v, run_left, m);
    above_min[c] = m[PIXEL_BITS-1:0];
    run_left     = m[PIXEL_BITS-1:0];
    row_end  = (col_idx + 1 >= w);
    grid_end = row_end && (row_idx + 1 >= h);
    if (!row_end) begin
      col_idx++;
    end else begin
      col_idx = 0;
      if (!grid_end) begin
        row_idx++;
      end else begin
        sweep_up(h, w);
        if (any_pair) begin
          res.cost  = (best_sum > COST_ALL_ONES) ? COST_ALL_ONES : best_sum[RESULT_BITS-1:0];
          res.found = 1'b1;
        end else begin
          res = '0;
        end
        pair_cost_q.push_back(res);
        clear_grid();
      end
    end
  endtask

  // Watch all three channels at each edge
  always @(posedge clk) begin : watch
    pair_result_t due;
    if (rst) begin
      rows_reg = HEIGHT_RESET;
      cols_reg = WIDTH_RESET;
      cost_reg = COST_RESET;
      clear_grid();
      pair_cost_q.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_valid && out_ready) begin
        if (pair_cost_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual min_cost %0d found %0b",
                   $time, min_cost, found);
        end else begin
          due = pair_cost_q.pop_front();
          if (min_cost !== due.cost) begin
            errors++;
            $display("%0t: min_cost mismatch: expected %0d, actual %0d",
                     $time, due.cost, min_cost);
          end
          if (found !== due.found) begin
            errors++;
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, due.found, found);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEIGHT: rows_reg = cfg_data[SIZE_BITS-1:0];
          REG_WIDTH:  cols_reg = cfg_data[SIZE_BITS-1:0];
          REG_COST:   cost_reg = cfg_data[COST_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_pixel(pixel);
    end
    results_due <= pair_cost_q.size();
    fail_count  <= errors;
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for grid_min_pair_l1_cost, with random stalls on both
// channels. Depends on gmp_pkg, the block and gmp_checker, which predicts and compares every result.

module tb_top;

  import gmp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PIXEL_TARGET = 1050;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_LIMIT  = 200_000;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic [DEF_PIXEL_BITS-1:0] pixel = '0;
  logic                      out_ready = 1'b0;
  logic                      cfg_ready;
  logic                      in_ready;
  logic                      out_valid;
  logic [RESULT_BITS-1:0]    min_cost;
  logic                      found;

  int fail_count;
  int results_due;
  int pixels_sent = 0;
  int cycle_count = 0;
  int grid_pixels = 4;
  bit hold_results = 1'b0;
  bit no_gaps = 1'b0;

  grid_min_pair_l1_cost i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_cost  (min_cost),
    .found     (found)
  );

  gmp_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .min_cost    (min_cost),
    .found       (found),
    .results_due (results_due),
    .fail_count  (fail_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** grid_min_pair_l1_cost: FAILED **");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DEF_PIXEL_BITS-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    if (r < 60) return DEF_PIXEL_BITS'($urandom_range(0, 31));
    if (r < 70) return DEF_PIXEL_BITS'($urandom_range(65500, 65535));
    return DEF_PIXEL_BITS'($urandom);
  endfunction

  function automatic logic [COST_BITS-1:0] pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 65) return COST_BITS'($urandom_range(0, 16));
    return COST_BITS'($urandom);
  endfunction

  // Size write, sometimes with junk above the 9 size bits
  function automatic logic [CFG_DATA_BITS-1:0] size_word(input int unsigned v);
    logic [CFG_DATA_BITS-1:0] w;
    w = CFG_DATA_BITS'(v[SIZE_BITS-1:0]);
    if ($urandom_range(0, 3) == 0) w = w | (16'($urandom) & 16'hFE00);
    return w;
  endfunction

  function automatic int clamp_dim(input logic [SIZE_BITS-1:0] v, input int limit);
    if (v == 0) return 1;
    return (v > limit) ? limit : int'(v);
  endfunction

  // Register write; valid drops for one cycle after each transfer
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pixel transfer; valid stays up into the next item when no gap is drawn
  task automatic send_pixel(input logic [DEF_PIXEL_BITS-1:0] v);
    int gap;
    gap = pick_gap(no_gaps);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_BITS-1:0] h, input logic [CFG_DATA_BITS-1:0] w,
                           input logic [COST_BITS-1:0] cost);
    wait_idle();
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_COST, cost);
    grid_pixels = clamp_dim(h[SIZE_BITS-1:0], DEF_MAX_HEIGHT)
                * clamp_dim(w[SIZE_BITS-1:0], DEF_MAX_WIDTH);
  endtask

  // Result side: random stalls, long ready stretches, one long hold-off on request
  initial begin : result_sink
    int span;
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      span = pick_gap(1'b0);
      if (span > 0) begin
        out_ready <= 1'b0;
        repeat (span) @(posedge clk);
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned h_raw;
    int unsigned w_raw;
    int unsigned strip_len;
    int          strips_left;
    int          sel;
    int          waited;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes (2 x 2, cost 1), pixel extremes and alternating bits
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    // single cell: no pair
    configure(16'd1, 16'd1, 16'd1);
    send_pixel(16'h1234);
    // zero sizes count as one
    configure(16'd0, 16'd0, 16'd5);
    send_pixel(16'hFFFF);
    // zero cost, unused register index
    configure(16'd1, 16'd2, 16'd0);
    write_reg(REG_SPARE, 16'h5A5A);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    // largest possible sum
    configure(16'd1, 16'd2, 16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    // single column
    configure(16'd3, 16'd1, 16'd7);
    send_pixel(16'd5);
    send_pixel(16'd0);
    send_pixel(16'd9);
    configure(16'd2, 16'd3, 16'd2);
    repeat (6) send_pixel(pick_pixel());

    // Back pressure: results held off while small grids keep coming
    configure(16'd2, 16'd2, 16'd3);
    hold_results = 1'b1;
    // start sending once the hold-off is under way
    while (hold_results) @(posedge clk);
    repeat (40) send_pixel(pick_pixel());

    // Random grids, mostly small; two long strips hit the size limits
    strips_left = 2;
    while (pixels_sent < PIXEL_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        sel = $urandom_range(0, 99);
        if (strips_left > 0 && (sel < 4 || pixels_sent > 500)) begin
          if (strips_left == 2) begin
            h_raw = 1;
            w_raw = DEF_MAX_WIDTH;
          end else begin
            strip_len = $urandom_range(DEF_MAX_HEIGHT + 1, 511);
            h_raw = strip_len;
            w_raw = 1;
          end
          strips_left--;
        end else if (sel < 12) begin
          h_raw = $urandom_range(0, 3);
          w_raw = $urandom_range(0, 3);
        end else begin
          h_raw = $urandom_range(1, 6);
          w_raw = $urandom_range(1, 6);
        end
        configure(size_word(h_raw), size_word(w_raw), pick_cost());
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat (grid_pixels) send_pixel(pick_pixel());
    end
    no_gaps = 1'b0;

    // Drain, then watch a while longer for stray results
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (results_due != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("** grid_min_pair_l1_cost: PASSED **");
    end else begin
      $display("** grid_min_pair_l1_cost: FAILED **");
    end
    $finish;
  end

endmodule
